FILE: rtl/core/dad_pkg.sv
// Shared constants, calendar tables and microcode types for the date adder.
// Used by dad_seq (program store) and date_add_days_top (datapath).
// No dependencies.
package dad_pkg;

  // Default width of the signed day offset
  localparam int OFFSET_BITS_DEF = 23;

  // Ten thousand years: 25 Gregorian cycles of 146097 days
  localparam logic [21:0] SPAN_DAYS = 22'd3652425;
  localparam logic [13:0] YEAR_SPAN = 14'd10000;

  // floor(y / 100) as (y * 5243) >> 19, exact for any 14-bit year
  localparam logic [26:0] CENT_MUL = 27'd5243;
  localparam int          CENT_SH  = 19;

  // Year estimate floor(pos * 45932 / 2^24): never above the true year,
  // at most two below it
  localparam logic [37:0] EST_MUL = 38'd45932;
  localparam int          EST_SH  = 24;

  // Program step width and jump targets
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MOD    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_YNEXT  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MONTH  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd14;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_ACCEPT,    // wait for a word, capture it
    OP_CENT_CUR,  // century of the year under test
    OP_DBY_CUR,   // days before the year under test, leap flag
    OP_CHECK,     // validate date, form start position plus offset
    OP_MOD,       // one reduction step modulo the 10000-year span
    OP_FIX,       // final fold of a negative remainder
    OP_EST,       // year estimate from the day position
    OP_CENT_NXT,  // century of the following year
    OP_DBY_NXT,   // days before the following year
    OP_YTEST,     // step the year when the next one already started
    OP_DOY,       // day of year
    OP_MONTH,     // peel one month off the day of year
    OP_EMIT       // load the result register
  } op_t;

  // Jump conditions: on true go to the target, else to the next step
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_BAD,
    C_KNZ,
    C_YMORE,
    C_MMORE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;   // input word offered
    logic out_free;   // result register can take a word
    logic bad;        // captured date is illegal
    logic k_nz;       // more reduction steps to go
    logic yr_more;    // following year starts at or before the position
    logic mon_more;   // day of year lies past the current month
  } stat_t;

  // Days in a month, leap-year aware; meaningless months give 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/date_add_days_top.sv
// Gregorian date plus signed day offset, microcoded datapath around dad_seq.
// Depends on dad_pkg and dad_seq.
//
// Usage: one word on the in_ channel carries a start date and a signed day
// offset; one word on the out_ channel returns the shifted date. Years wrap
// modulo 10000 both ways. An illegal start date comes back unchanged with
// out_tuser (valid_res) low.
// One word at a time: the next word is taken only after the result is loaded.
// A legal date runs, among its other steps, KSTEPS = max(22, OFFSET_BITS) - 20
// reduction steps of the span modulo, YSTEPS = 1..3 passes of the year test
// after the reciprocal estimate and MSTEPS = 1..12 month steps, the upper end
// for December dates. An illegal date goes from the check straight to the
// result step. The program returns to its accept step in the cycle after the
// result is loaded. The program counter in dad_seq sets the pace; the
// century and days-before-year steps use the single shared year unit
// (century multiply, then days-before-year).
// in_tready is high only while the program waits at its accept step.
// Reset (rst_n low, synchronous) returns the program to that step and
// drops out_tvalid. When the receiver stalls, the result stays in the
// output register and the program waits before loading the next one.
module date_add_days_top
  import dad_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int IN_W = ((23 + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // day_in[5], month_in[4], year_in[14], offset
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata,  // day_out[5], month_out[4], year_out[14], pad
  output logic            out_tuser   // valid_res
);

  localparam int SUM_W = ((OFFSET_BITS > 22) ? OFFSET_BITS : 22) + 2;
  localparam int K_MAX = SUM_W - 23;
  localparam int K_W   = $clog2(K_MAX + 1);

  ctrl_t ctrl;
  stat_t stat;

  // Captured word
  logic [4:0]             d_r;
  logic [3:0]             m_r;
  logic [13:0]            y_r;
  logic [OFFSET_BITS-1:0] off_r;

  // Working registers
  logic [13:0]             ty_r;     // year under test
  logic [7:0]              cent_r;
  logic [22:0]             dby_r;
  logic                    leap_r;
  logic signed [SUM_W-1:0] acc_r;    // position, then reduced position
  logic [K_W-1:0]          k_r;
  logic [3:0]              mo_r;
  logic [8:0]              doy_r;
  logic                    bad_r;

  // Result register
  logic        out_tvalid_r;
  logic [4:0]  day_out_r;
  logic [3:0]  month_out_r;
  logic [13:0] year_out_r;
  logic        valid_res_r;

  logic                    accept;
  logic                    emit;
  logic [13:0]             yop;
  logic [26:0]             cent_prod;
  logic [13:0]             rem_y;
  logic                    rem_nz;
  logic [8:0]              cc;
  logic [8:0]              c_ceil4;
  logic [14:0]             y_ceil4;
  logic [22:0]             dby_val;
  logic                    leap_val;
  logic                    bad;
  logic [22:0]             pos0;
  logic signed [SUM_W-1:0] sum0;
  logic signed [SUM_W-1:0] span_k;
  logic signed [SUM_W-1:0] span_1;
  logic [21:0]             pos;
  logic [37:0]             est_prod;
  logic [4:0]              mlen;

  // Sequencer
  dad_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_tready = (ctrl.op == OP_ACCEPT);
  assign accept    = in_tvalid && in_tready;
  assign emit      = (ctrl.op == OP_EMIT) && stat.out_free;

  // Shared year unit: operand is the year under test or the one after
  assign yop = ((ctrl.op == OP_CENT_NXT) || (ctrl.op == OP_DBY_NXT)) ? (ty_r + 14'd1) : ty_r;

  assign cent_prod = {13'd0, yop} * CENT_MUL;
  assign rem_y     = yop - ({6'd0, cent_r} * 14'd100);
  assign rem_nz    = (rem_y != 14'd0);
  assign cc        = {1'b0, cent_r} + {8'd0, rem_nz};   // ceil(y / 100)
  assign c_ceil4   = (cc + 9'd3) >> 2;                  // ceil(y / 400)
  assign y_ceil4   = ({1'b0, yop} + 15'd3) >> 2;
  assign dby_val   = ({9'd0, yop} * 23'd365) + {8'd0, y_ceil4} - {14'd0, cc}
                   + {16'd0, c_ceil4[6:0]};
  assign leap_val  = rem_nz ? (yop[1:0] == 2'b00) : (cent_r[1:0] == 2'b00);

  // Legality of the captured date
  assign bad = (m_r == 4'd0) || (m_r > 4'd12) || (y_r >= YEAR_SPAN) ||
               (d_r == 5'd0) || (d_r > month_len(m_r, leap_r));

  // Start position plus offset
  assign pos0 = dby_r + {14'd0, days_before_month(m_r, leap_r)} + {18'd0, d_r} - 23'd1;
  assign sum0 = $signed({{(SUM_W-23){1'b0}}, pos0}) +
                $signed({{(SUM_W-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r});

  // Span scaled for the current reduction step
  assign span_1 = $signed({{(SUM_W-22){1'b0}}, SPAN_DAYS});
  assign span_k = span_1 <<< k_r;

  assign pos      = acc_r[21:0];
  assign est_prod = {16'd0, pos} * EST_MUL;
  assign mlen     = month_len(mo_r, leap_r);

  // Status to the sequencer
  assign stat.in_valid = in_tvalid;
  assign stat.out_free = !out_tvalid_r || out_tready;
  assign stat.bad      = bad;
  assign stat.k_nz     = (k_r != '0);
  assign stat.yr_more  = ({1'b0, pos} >= dby_r);
  assign stat.mon_more = (mo_r < 4'd12) && (doy_r >= {4'd0, mlen});

  // Datapath
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (accept) begin
          d_r   <= in_tdata[4:0];
          m_r   <= in_tdata[8:5];
          y_r   <= in_tdata[22:9];
          off_r <= in_tdata[22+OFFSET_BITS:23];
          ty_r  <= in_tdata[22:9];
        end
      end
      OP_CENT_CUR, OP_CENT_NXT: begin
        cent_r <= cent_prod[CENT_SH+7:CENT_SH];
      end
      OP_DBY_CUR, OP_DBY_NXT: begin
        dby_r  <= dby_val;
        leap_r <= leap_val;
      end
      OP_CHECK: begin
        bad_r <= bad;
        acc_r <= sum0;
        k_r   <= K_W'(K_MAX);
      end
      OP_MOD: begin
        if (acc_r < 0) begin
          acc_r <= acc_r + span_k;
        end else if (acc_r >= span_k) begin
          acc_r <= acc_r - span_k;
        end
        if (k_r != '0) begin
          k_r <= k_r - 1'b1;
        end
      end
      OP_FIX: begin
        if (acc_r < 0) begin
          acc_r <= acc_r + span_1;
        end
      end
      OP_EST: begin
        ty_r <= est_prod[EST_SH+13:EST_SH];
      end
      OP_YTEST: begin
        if (stat.yr_more) begin
          ty_r <= ty_r + 14'd1;
        end
      end
      OP_DOY: begin
        doy_r <= 9'(pos - dby_r[21:0]);
        mo_r  <= 4'd1;
      end
      OP_MONTH: begin
        if (stat.mon_more) begin
          doy_r <= doy_r - {4'd0, mlen};
          mo_r  <= mo_r + 4'd1;
        end
      end
      OP_EMIT: begin
        if (emit) begin
          if (bad_r) begin
            day_out_r   <= d_r;
            month_out_r <= m_r;
            year_out_r  <= y_r;
            valid_res_r <= 1'b0;
          end else begin
            day_out_r   <= 5'(doy_r + 9'd1);
            month_out_r <= mo_r;
            year_out_r  <= ty_r;
            valid_res_r <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, year_out_r, month_out_r, day_out_r};
  assign out_tuser  = valid_res_r;

endmodule

FILE: rtl/core/dad_seq.sv
// Microcode sequencer for the date adder: program store and step counter.
// Depends on dad_pkg for the control word, status and step constants.
module dad_seq
  import dad_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic              hold;
  logic              take;

  // Program store
  always_comb begin
    unique case (pc_r)
      4'd0:    ctrl = '{op: OP_ACCEPT,   cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd1:    ctrl = '{op: OP_CENT_CUR, cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd2:    ctrl = '{op: OP_DBY_CUR,  cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd3:    ctrl = '{op: OP_CHECK,    cond: C_BAD,   tgt: STEP_EMIT};
      4'd4:    ctrl = '{op: OP_MOD,      cond: C_KNZ,   tgt: STEP_MOD};
      4'd5:    ctrl = '{op: OP_FIX,      cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd6:    ctrl = '{op: OP_EST,      cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd7:    ctrl = '{op: OP_CENT_NXT, cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd8:    ctrl = '{op: OP_DBY_NXT,  cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd9:    ctrl = '{op: OP_YTEST,    cond: C_YMORE, tgt: STEP_YNEXT};
      4'd10:   ctrl = '{op: OP_CENT_CUR, cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd11:   ctrl = '{op: OP_DBY_CUR,  cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd12:   ctrl = '{op: OP_DOY,      cond: C_NEXT,  tgt: STEP_ACCEPT};
      4'd13:   ctrl = '{op: OP_MONTH,    cond: C_MMORE, tgt: STEP_MONTH};
      4'd14:   ctrl = '{op: OP_EMIT,     cond: C_JUMP,  tgt: STEP_ACCEPT};
      default: ctrl = '{op: OP_ACCEPT,   cond: C_JUMP,  tgt: STEP_ACCEPT};
    endcase
  end

  // Stall on the handshake steps
  assign hold = ((ctrl.op == OP_ACCEPT) && !stat.in_valid) ||
                ((ctrl.op == OP_EMIT) && !stat.out_free);

  // Jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:  take = 1'b0;
      C_JUMP:  take = 1'b1;
      C_BAD:   take = stat.bad;
      C_KNZ:   take = stat.k_nz;
      C_YMORE: take = stat.yr_more;
      C_MMORE: take = stat.mon_more;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.tgt;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
